// File: src/assert_macros.svh
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/pedd_pkg.sv
// ----------------------------------------------------------------------------
// pedd_pkg
// Shared constants and types of the palette error-diffusion ditherer.
// ----------------------------------------------------------------------------
`default_nettype none

package pedd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int PAL_DEPTH   = 255;
  localparam int LINE_DEPTH  = MAX_WIDTH + 2;
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int PAL_AW      = $clog2(PAL_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ERR_W       = 13;
  localparam int SCORE_W     = 18;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_PAL_COUNT = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_ZRD,
    ST_ZWR,
    ST_ADJ,
    ST_SRCH,
    ST_U0,
    ST_U1,
    ST_U2,
    ST_U3
  } state_e;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] y;
    logic signed [ERR_W-1:0] cb;
    logic signed [ERR_W-1:0] cr;
  } err_t;

  typedef struct packed {
    logic signed [8:0] y;
    logic signed [8:0] cb;
    logic signed [8:0] cr;
  } diff_t;

endpackage

`default_nettype wire

// File: src/palette_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither
// Each pixel passes through the adjust, palette search and error update states,
// after the zero read and write states at column 0; the search reads one palette
// entry per cycle from its memory. One pixel in flight; the next one waits for the result.
// Reset, start and image end run a clearing pass over all 1026 error line entries.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_error_diffusion_dither
  import pedd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       color_index_o,
  output logic             row_end_o,
  output logic             image_end_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  function automatic logic [9:0] fix_q16(input logic signed [25:0] s);
    logic signed [25:0] t;
    t = s + (s[25] ? 26'sd65535 : 26'sd0);
    return t[25:16];
  endfunction

  function automatic ycc_t to_ycc(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    logic signed [25:0] rs, gs, bs;
    logic [9:0] qy, qb, qr;
    ycc_t o;
    rs = $signed({18'd0, r});
    gs = $signed({18'd0, g});
    bs = $signed({18'd0, b});
    qy = fix_q16(rs * 26'sd19595 + gs * 26'sd38470 + bs * 26'sd7471);
    qb = fix_q16(bs * 26'sd32768 - rs * 26'sd11059 - gs * 26'sd21709);
    qr = fix_q16(rs * 26'sd32768 - gs * 26'sd27439 - bs * 26'sd5329);
    o.y  = qy[7:0];
    o.cb = qb[7:0] + 8'd128;
    o.cr = qr[7:0] + 8'd128;
    return o;
  endfunction

  function automatic logic [7:0] adj(input logic [7:0] c, input logic signed [ERR_W-1:0] v);
    logic signed [ERR_W-1:0] t;
    logic signed [10:0] s;
    t = v + (v[ERR_W-1] ? ERR_W'(15) : ERR_W'(0));
    s = $signed({3'd0, c}) + 11'($signed(t[ERR_W-1:4]));
    if (s < 0) begin
      return 8'd0;
    end else if (s > 11'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  function automatic err_t err_mac(input err_t b, input diff_t e, input logic [2:0] k);
    logic signed [3:0] ks;
    err_t o;
    ks = $signed({1'b0, k});
    o.y  = b.y  + ERR_W'(e.y  * ks);
    o.cb = b.cb + ERR_W'(e.cb * ks);
    o.cr = b.cr + ERR_W'(e.cr * ks);
    return o;
  endfunction

  state_e state_q, state_d;

  logic [7:0]         pal_cnt_q;
  logic [10:0]        img_w_q;
  logic [15:0]        img_h_q;
  logic [LINE_AW-1:0] clr_cnt_q;
  logic [COL_W-1:0]   col_cnt_q;
  logic [15:0]        row_cnt_q;
  err_t               run_q;
  logic [7:0]         k_q;
  logic               p1_q, p2_q, have_q;
  logic               out_valid_q;

  ycc_t               conv_q, pix_q;
  logic [COL_W-1:0]   col_q;
  logic               row_last_q, img_last_q;
  logic [7:0]         p1_idx_q, p2_idx_q, best_idx_q;
  logic [SCORE_W-1:0] sc_q, best_sc_q;
  diff_t              ed_q, best_e_q;
  logic [7:0]         color_q;
  logic               row_end_q, image_end_q;

  ycc_t               pal_mem [PAL_DEPTH];
  ycc_t               pal_rdata_q;
  err_t               line_mem [LINE_DEPTH];
  err_t               line_rdata_q;

  logic               line_we;
  logic [LINE_AW-1:0] line_waddr, line_raddr;
  err_t               line_wdata;
  logic               issue;
  logic               in_acc, out_free, srch_done;

  logic [7:0]         cnt;
  logic [10:0]        w;
  logic [COL_W-1:0]   wm1, col_c;
  logic [15:0]        hm1;
  logic               row_last_c;
  ycc_t               conv_c;
  diff_t              d_c;
  logic signed [17:0] sq_y, sq_b, sq_r;
  logic [LINE_AW-1:0] a_col, a_col1, a_col2;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cnt = pal_cnt_q;
    if (pal_cnt_q < 8'd2) begin
      cnt = 8'd2;
    end else if ({1'b0, pal_cnt_q} > 9'(PAL_DEPTH)) begin
      cnt = 8'(PAL_DEPTH);
    end
    w = img_w_q;
    if (img_w_q == 11'd0) begin
      w = 11'd1;
    end else if (img_w_q > 11'(MAX_WIDTH)) begin
      w = 11'(MAX_WIDTH);
    end
    wm1 = COL_W'(w - 11'd1);
    hm1 = (img_h_q == 16'd0) ? 16'd0 : img_h_q - 16'd1;
    col_c = (col_cnt_q > wm1) ? wm1 : col_cnt_q;
    row_last_c = (col_c >= wm1);
    conv_c = to_ycc(red_i, green_i, blue_i);
  end

  assign a_col  = LINE_AW'(col_q);
  assign a_col1 = a_col + LINE_AW'(1);
  assign a_col2 = a_col + LINE_AW'(2);

  assign srch_done = (k_q == cnt) && !p1_q && !p2_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR: begin
        if (clr_cnt_q == LINE_AW'(LINE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_i)
            CMD_PIXEL: state_d = (col_c == '0) ? ST_ZRD : ST_ADJ;
            CMD_START: state_d = ST_CLR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ZRD:  state_d = ST_ZWR;
      ST_ZWR:  state_d = ST_ADJ;
      ST_ADJ:  state_d = ST_SRCH;
      ST_SRCH: begin
        if (srch_done) state_d = ST_U0;
      end
      ST_U0:   state_d = ST_U1;
      ST_U1:   state_d = ST_U2;
      ST_U2:   state_d = ST_U3;
      ST_U3: begin
        if (out_free) state_d = img_last_q ? ST_CLR : ST_IDLE;
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_comb begin
    line_we    = 1'b0;
    line_waddr = a_col;
    line_wdata = '0;
    line_raddr = a_col;
    issue      = 1'b0;
    case (state_q)
      ST_CLR: begin
        line_we    = 1'b1;
        line_waddr = clr_cnt_q;
      end
      ST_ZRD: line_raddr = LINE_AW'(1);
      ST_ZWR: begin
        line_we    = 1'b1;
        line_waddr = LINE_AW'(1);
      end
      ST_SRCH: issue = (k_q != cnt);
      ST_U0: line_raddr = a_col2;
      ST_U1: begin
        line_we    = 1'b1;
        line_waddr = a_col2;
        line_wdata = err_mac('0, best_e_q, 3'd1);
        line_raddr = a_col1;
      end
      ST_U2: begin
        line_we    = 1'b1;
        line_waddr = a_col1;
        line_wdata = err_mac(line_rdata_q, best_e_q, 3'd5);
      end
      ST_U3: begin
        line_we    = out_free && (col_q != '0);
        line_wdata = err_mac(line_rdata_q, best_e_q, 3'd3);
      end
      default: line_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (cmd_i == CMD_LOAD) && ({1'b0, entry_index_i} < 9'(PAL_DEPTH))) begin
      pal_mem[entry_index_i[PAL_AW-1:0]] <= conv_c;
    end
    pal_rdata_q <= pal_mem[k_q[PAL_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_waddr] <= line_wdata;
    line_rdata_q <= line_mem[line_raddr];
  end

  always_comb begin
    d_c.y  = $signed({1'b0, pix_q.y})  - $signed({1'b0, pal_rdata_q.y});
    d_c.cb = $signed({1'b0, pix_q.cb}) - $signed({1'b0, pal_rdata_q.cb});
    d_c.cr = $signed({1'b0, pix_q.cr}) - $signed({1'b0, pal_rdata_q.cr});
    sq_y   = d_c.y  * d_c.y;
    sq_b   = d_c.cb * d_c.cb;
    sq_r   = d_c.cr * d_c.cr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      pal_cnt_q   <= 8'd2;
      img_w_q     <= 11'd1;
      img_h_q     <= 16'd1;
      clr_cnt_q   <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      run_q       <= '0;
      k_q         <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PAL_COUNT: pal_cnt_q <= cfg_data_i[7:0];
          CFG_WIDTH:     img_w_q   <= cfg_data_i[10:0];
          CFG_HEIGHT:    img_h_q   <= cfg_data_i;
          default:       pal_cnt_q <= pal_cnt_q;
        endcase
      end
      if ((state_q == ST_U3) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      p1_q <= issue;
      p2_q <= p1_q;
      case (state_q)
        ST_CLR: begin
          clr_cnt_q <= (clr_cnt_q == LINE_AW'(LINE_DEPTH - 1)) ? '0 : clr_cnt_q + 1'b1;
          col_cnt_q <= '0;
          row_cnt_q <= '0;
          run_q     <= '0;
        end
        ST_ZWR: run_q <= line_rdata_q;
        ST_ADJ: begin
          k_q    <= '0;
          have_q <= 1'b0;
        end
        ST_SRCH: begin
          if (issue) k_q <= k_q + 1'b1;
          if (p2_q && (!have_q || sc_q < best_sc_q)) have_q <= 1'b1;
        end
        ST_U1: run_q <= err_mac(line_rdata_q, best_e_q, 3'd7);
        ST_U3: begin
          if (out_free) begin
            if (row_last_q) begin
              col_cnt_q <= '0;
              row_cnt_q <= row_cnt_q + 1'b1;
            end else begin
              col_cnt_q <= col_q + 1'b1;
            end
          end
        end
        default: k_q <= k_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      conv_q     <= conv_c;
      col_q      <= col_c;
      row_last_q <= row_last_c;
      img_last_q <= row_last_c && (row_cnt_q >= hm1);
    end
    if (state_q == ST_ADJ) begin
      pix_q.y  <= adj(conv_q.y,  run_q.y);
      pix_q.cb <= adj(conv_q.cb, run_q.cb);
      pix_q.cr <= adj(conv_q.cr, run_q.cr);
    end
    p1_idx_q <= k_q;
    p2_idx_q <= p1_idx_q;
    sc_q     <= SCORE_W'($unsigned(sq_y)) + SCORE_W'($unsigned(sq_b))
              + SCORE_W'($unsigned(sq_r));
    ed_q     <= d_c;
    if ((state_q == ST_SRCH) && p2_q && (!have_q || sc_q < best_sc_q)) begin
      best_idx_q <= p2_idx_q;
      best_sc_q  <= sc_q;
      best_e_q   <= ed_q;
    end
    if ((state_q == ST_U3) && out_free) begin
      color_q     <= best_idx_q;
      row_end_q   <= row_last_q;
      image_end_q <= img_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_q;
  assign row_end_o     = row_end_q;
  assign image_end_o   = image_end_q;

endmodule

`default_nettype wire

// File: src/pedd_checker.sv
// ----------------------------------------------------------------------------
// pedd_checker
// Port-level checks of the ditherer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pedd_checker
  import pedd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  cmd_i,
  input wire logic [7:0]  entry_index_i,
  input wire logic [7:0]  red_i,
  input wire logic [7:0]  green_i,
  input wire logic [7:0]  blue_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  color_index_o,
  input wire logic        row_end_o,
  input wire logic        image_end_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [1:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i
);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
              out_valid_o && $stable(color_index_o) && $stable(row_end_o) && $stable(image_end_o))

  `ASSERT_IMP(a_img_row, clk_i, rst_ni, out_valid_o && image_end_o, row_end_o)

  `ASSERT_NXT(a_busy_pix, clk_i, rst_ni,
              in_valid_i && !in_stall_o && (cmd_i == CMD_PIXEL || cmd_i == CMD_START),
              in_stall_o)

  `ASSERT_NXT(a_load_ready, clk_i, rst_ni,
              in_valid_i && !in_stall_o && (cmd_i == CMD_LOAD),
              !in_stall_o)

endmodule

bind palette_error_diffusion_dither pedd_checker u_pedd_checker (.*);

`default_nettype wire

// File: sim/palette_error_diffusion_dither_checker.sv
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_checker
// Watches the pixel, result and register channels and keeps its own model of
// the ditherer: palette in YCbCr, one-line error store, position counters.
// Each pixel transaction queues a predicted result, and each result
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_checker
  import pedd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  color_index_i,
  input  logic        row_end_i,
  input  logic        image_end_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [7:0] color_index;
    logic       row_end;
    logic       image_end;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];

  int pal_y[PAL_DEPTH], pal_cb[PAL_DEPTH], pal_cr[PAL_DEPTH];
  int line_y[LINE_DEPTH], line_cb[LINE_DEPTH], line_cr[LINE_DEPTH];
  int carry_y, carry_cb, carry_cr;
  int col_pos, row_pos;
  int pal_count_reg, width_reg, height_reg;

  function automatic void rgb_to_ycc(input int r, input int g, input int b,
                                     output int y, output int cb, output int cr);
    y  = (r * 19595 + g * 38470 + b * 7471) / 65536;
    cb = (r * -11059 + g * -21709 + b * 32768) / 65536 + 128;
    cr = (r * 32768 + g * -27439 + b * -5329) / 65536 + 128;
  endfunction

  function automatic int sat8(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic clear_image();
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_y[i] = 0; line_cb[i] = 0; line_cr[i] = 0;
    end
    carry_y = 0; carry_cb = 0; carry_cr = 0;
    col_pos = 0; row_pos = 0;
  endtask

  task automatic dither_pixel(input int r, input int g, input int b);
    int cnt, w, h, col, py, pcb, pcr, best, top_score, score;
    int ey, ecb, ecr, dy, dcb, dcr, right;
    pixel_result_t res;
    cnt = (pal_count_reg < 2) ? 2 : (pal_count_reg > PAL_DEPTH) ? PAL_DEPTH : pal_count_reg;
    w = (width_reg < 1) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg < 1) ? 1 : height_reg;
    col = (col_pos > w - 1) ? w - 1 : col_pos;
    if (col == 0) begin
      carry_y = line_y[1]; carry_cb = line_cb[1]; carry_cr = line_cr[1];
      line_y[1] = 0; line_cb[1] = 0; line_cr[1] = 0;
    end
    rgb_to_ycc(r, g, b, py, pcb, pcr);
    py  = sat8(py + carry_y / 16);
    pcb = sat8(pcb + carry_cb / 16);
    pcr = sat8(pcr + carry_cr / 16);
    best = 0; top_score = 32'h7fffffff; ey = 0; ecb = 0; ecr = 0;
    for (int k = 0; k < cnt; k++) begin
      dy = py - pal_y[k]; dcb = pcb - pal_cb[k]; dcr = pcr - pal_cr[k];
      score = dy * dy + dcb * dcb + dcr * dcr;
      if (score < top_score) begin
        best = k; top_score = score; ey = dy; ecb = dcb; ecr = dcr;
      end
    end
    right = col + 2;
    carry_y  = ey * 7 + line_y[right];
    carry_cb = ecb * 7 + line_cb[right];
    carry_cr = ecr * 7 + line_cr[right];
    if (col > 0) begin
      line_y[col] += ey * 3; line_cb[col] += ecb * 3; line_cr[col] += ecr * 3;
    end
    line_y[col + 1] += ey * 5; line_cb[col + 1] += ecb * 5; line_cr[col + 1] += ecr * 5;
    line_y[right] = ey; line_cb[right] = ecb; line_cr[right] = ecr;
    res.color_index = best[7:0];
    res.row_end     = (col >= w - 1);
    res.image_end   = res.row_end && (row_pos >= h - 1);
    expected_pixels.push_back(res);
    if (res.image_end) begin
      clear_image();
    end else if (res.row_end) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 16'hffff;
    end else begin
      col_pos = col + 1;
    end
  endtask

  initial begin
    for (int i = 0; i < PAL_DEPTH; i++) begin
      pal_y[i] = 0; pal_cb[i] = 0; pal_cr[i] = 0;
    end
    clear_image();
    pal_count_reg = 2; width_reg = 1; height_reg = 1;
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    pixel_result_t exp_px;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PAL_COUNT: pal_count_reg = cfg_data_i & 16'h00ff;
          CFG_WIDTH:     width_reg = cfg_data_i & 16'h07ff;
          CFG_HEIGHT:    height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (cmd_e'(cmd_i))
          CMD_LOAD: begin
            if (entry_index_i < PAL_DEPTH)
              rgb_to_ycc(red_i, green_i, blue_i, pal_y[entry_index_i],
                         pal_cb[entry_index_i], pal_cr[entry_index_i]);
          end
          CMD_START: clear_image();
          CMD_PIXEL: dither_pixel(red_i, green_i, blue_i);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transaction: color_index %0d", color_index_i);
          fail_count_o++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (color_index_i !== exp_px.color_index) begin
            $error("color_index expected %0d actual %0d", exp_px.color_index, color_index_i);
            fail_count_o++;
          end
          if (row_end_i !== exp_px.row_end) begin
            $error("row_end expected %0d actual %0d", exp_px.row_end, row_end_i);
            fail_count_o++;
          end
          if (image_end_i !== exp_px.image_end) begin
            $error("image_end expected %0d actual %0d", exp_px.image_end, image_end_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// File: sim/palette_error_diffusion_dither_test.sv
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_test
// Drives palette loads, image starts and pixels through the ditherer under
// random idling on both sides, rewrites the registers between phases, and
// leaves the result checking to the checker instance beside the block.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither_test;
  import pedd_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int SETTLE_CYCLES    = 1400;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  cmd;
  logic [7:0]  entry_index, red, green, blue;
  logic        out_valid, out_stall;
  logic [7:0]  color_index;
  logic        row_end, image_end;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending;
  bit          calm;
  int          quiet_cycles;
  int          stall_left;

  palette_error_diffusion_dither dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .cmd_i(cmd),
    .entry_index_i(entry_index), .red_i(red), .green_i(green), .blue_i(blue),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .color_index_o(color_index),
    .row_end_o(row_end), .image_end_o(image_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  palette_error_diffusion_dither_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .cmd_i(cmd),
    .entry_index_i(entry_index), .red_i(red), .green_i(green), .blue_i(blue),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .color_index_i(color_index),
    .row_end_i(row_end), .image_end_i(image_end),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver idling: random bursts of stall or no stall
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(0, 18);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send(input logic [1:0] c, input logic [7:0] idx,
                      input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    entry_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send(CMD_PIXEL, 8'($urandom), r, g, b);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int pick;
    rst_n = 1'b0;
    in_valid = 1'b0; cmd = CMD_LOAD; entry_index = '0;
    red = '0; green = '0; blue = '0;
    out_stall = 1'b0; stall_left = 0;
    cfg_valid = 1'b0; cfg_index = CFG_PAL_COUNT; cfg_data = '0;
    calm = 1'b0; quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two-entry palette, single-pixel images
    write_reg(CFG_PAL_COUNT, 16'd0);
    send(CMD_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    send(CMD_LOAD, 8'd1, 8'hff, 8'hff, 8'hff);
    send(CMD_LOAD, 8'd255, 8'h12, 8'h34, 8'h56);
    pixel(8'h00, 8'h00, 8'h00);
    pixel(8'hff, 8'hff, 8'hff);
    pixel(8'hff, 8'h00, 8'h00);
    pixel(8'h00, 8'hff, 8'h00);
    pixel(8'h00, 8'h00, 8'hff);
    pixel(8'hff, 8'h00, 8'hff);
    send(CMD_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(CFG_PAL_COUNT, 16'd1);
    write_reg(CFG_WIDTH, 16'd3);
    write_reg(CFG_HEIGHT, 16'd2);
    pixel(8'h80, 8'h80, 8'h80);
    pixel(8'h7f, 8'h7f, 8'h7f);
    pixel(8'h80, 8'h80, 8'h80);
    pixel(8'h40, 8'hc0, 8'h20);
    pixel(8'h80, 8'h80, 8'h80);
    pixel(8'hff, 8'hff, 8'h00);
    pixel(8'h00, 8'hff, 8'hff);

    // load the whole palette, then the largest search
    for (int i = 0; i < PAL_DEPTH; i++)
      send(CMD_LOAD, 8'(i), pick_channel(), pick_channel(), pick_channel());
    settle();
    write_reg(CFG_PAL_COUNT, 16'h01ff);
    write_reg(CFG_WIDTH, 16'd2047);
    write_reg(CFG_HEIGHT, 16'd0);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (20) pixel(pick_channel(), pick_channel(), pick_channel());

    // widest row with the tallest image
    settle();
    write_reg(CFG_PAL_COUNT, 16'd4);
    write_reg(CFG_WIDTH, 16'd1024);
    write_reg(CFG_HEIGHT, 16'hffff);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (40) pixel(8'($urandom), 8'($urandom), 8'($urandom));

    // width shrinks under the current column
    settle();
    write_reg(CFG_WIDTH, 16'd8);
    write_reg(CFG_HEIGHT, 16'd3);
    send(CMD_START, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (5) pixel(pick_channel(), pick_channel(), pick_channel());
    settle();
    write_reg(CFG_WIDTH, 16'd3);
    repeat (6) pixel(pick_channel(), pick_channel(), pick_channel());

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      settle();
      if (ph == 9) calm = 1'b1;
      write_reg(CFG_PAL_COUNT, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(2, 255))
                                                          : 16'($urandom_range(2, 16)));
      write_reg(CFG_WIDTH, 16'($urandom_range(1, 12)));
      write_reg(CFG_HEIGHT, 16'($urandom_range(1, 4)));
      repeat (25) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          send(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 9)
          send(CMD_LOAD, 8'($urandom), pick_channel(), pick_channel(), pick_channel());
        else if (pick < 11)
          send(CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
          pixel(pick_channel(), pick_channel(), pick_channel());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/pedd_pkg.sv
src/palette_error_diffusion_dither.sv
src/pedd_checker.sv
sim/palette_error_diffusion_dither_checker.sv
sim/palette_error_diffusion_dither_test.sv
